/* sv/fesd_pkg.sv */
`timescale 1ns / 1ps

package fesd_pkg;

   localparam int STORE_ADDR_BITS = 16;
   localparam int FRAC_BITS       = 16;
   localparam int SAMPLE_W        = 32;
   localparam int WORD_W          = 16;
   localparam int CFG_W           = 17;
   localparam int REG_IDX_W       = 3;
   localparam int SNAP_DIST       = 10;

   localparam int FP_ONE_INT   = 1 << FRAC_BITS;
   localparam int SMOOTH_RESET = (FP_ONE_INT * 25 + 50000) / 100000;

   localparam logic [CFG_W-1:0] FP_ONE = CFG_W'(FP_ONE_INT);
   localparam logic [STORE_ADDR_BITS-1:0] STORE_MASK = '1;

   // multiplier operand widths: signed sample plus sign, unsigned gain plus sign
   localparam int MUL_A_W = SAMPLE_W + 1;
   localparam int MUL_B_W = CFG_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [REG_IDX_W-1:0] REG_OUT_GAIN     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MUTE         = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DELAY_TARGET = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DECAY        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SMOOTHING    = 3'd4;

   localparam logic [1:0] MUL_OFFSET   = 2'd0;
   localparam logic [1:0] MUL_TARGET   = 2'd1;
   localparam logic [1:0] MUL_FEEDBACK = 2'd2;
   localparam logic [1:0] MUL_GAIN     = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0]           out_gain;
      logic                       mute;
      logic [STORE_ADDR_BITS-1:0] delay_target;
      logic [CFG_W-1:0]           decay;
      logic [CFG_W-1:0]           smoothing;
   } cfg_type;

   typedef struct packed {
      logic       load_in;
      logic       mul_go;
      logic [1:0] mul_sel;
      logic       acc_load;
      logic       offs_load;
      logic       mem_read;
      logic       mem_write;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

/* sv/feedback_echo_with_smoothed_delay_core.sv */
`timescale 1ns / 1ps

// channel | direction | ports                          | handshake
// req     | in        | req_in_sample (s32)            | req_valid / req_ready
// rsp     | out       | rsp_out_sample (s32)           | rsp_valid / rsp_ready
// csr     | in        | csr_index, csr_wdata (17 bits) | csr_wr_en, no wait
//
// beats are taken one at a time: the single shared 33x18 multiplier is used four
// times per beat and the echo store port is used once to read, once to write
// a finished result waits in the output register while the next beat is taken
// reset is synchronous; the store is not swept, unwritten words read as zero
// rsp stalls hold only the final step, earlier steps run on

module feedback_echo_with_smoothed_delay_core
   import fesd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample,
   input  logic                       csr_wr_en,
   input  logic [REG_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   fesd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fesd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fesd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .cfg            (cfg),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("beat accepted while previous beat still in work");

   a_one_store_access: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_read && cmd.mem_write))
      else $error("store read and write in the same cycle");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

endmodule

/* sv/fesd_csr.sv */
`timescale 1ns / 1ps

module fesd_csr
   import fesd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [STORE_ADDR_BITS-1:0] target_val;

   assign target_val = csr_wdata[STORE_ADDR_BITS-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_OUT_GAIN: begin
               if (csr_wdata <= FP_ONE) cfg_in.out_gain = csr_wdata;
            end
            REG_MUTE: begin
               cfg_in.mute = csr_wdata[0];
            end
            REG_DELAY_TARGET: begin
               if (target_val != '0 && target_val <= STORE_MASK)
                  cfg_in.delay_target = target_val;
            end
            REG_DECAY: begin
               if (csr_wdata <= FP_ONE) cfg_in.decay = csr_wdata;
            end
            REG_SMOOTHING: begin
               if (csr_wdata <= FP_ONE) cfg_in.smoothing = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_gain     <= FP_ONE;
         cfg_ff.mute         <= 1'b0;
         cfg_ff.delay_target <= STORE_ADDR_BITS'(1);
         cfg_ff.decay        <= FP_ONE;
         cfg_ff.smoothing    <= CFG_W'(SMOOTH_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/fesd_ctrl.sv */
`timescale 1ns / 1ps

module fesd_ctrl
   import fesd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL_A = 4'd1;
   localparam logic [3:0] ST_MUL_B = 4'd2;
   localparam logic [3:0] ST_OFFS  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_FB    = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_GAIN  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_OFFSET;
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.acc_load = 1'b1;
            cmd.mul_go   = 1'b1;
            cmd.mul_sel  = MUL_TARGET;
            state_in     = ST_OFFS;
         end
         ST_OFFS: begin
            cmd.offs_load = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_FB;
         end
         ST_FB: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_FEEDBACK;
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MUL_GAIN;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* sv/fesd_dp.sv */
`timescale 1ns / 1ps

module fesd_dp
   import fesd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output stat_type                   stat,
   input  cfg_type                    cfg,
   input  logic signed [SAMPLE_W-1:0] req_in_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_out_sample
);

   localparam int STORE_SIZE = 1 << STORE_ADDR_BITS;
   localparam int FB_W       = PROD_W + WORD_W;

   logic [WORD_W-1:0] echo_mem [STORE_SIZE];

   logic signed [SAMPLE_W-1:0] in_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [STORE_ADDR_BITS-1:0] acc_ff;
   logic [STORE_ADDR_BITS-1:0] offset_ff;
   logic [STORE_ADDR_BITS-1:0] offset_in;
   logic [STORE_ADDR_BITS-1:0] wp_ff;
   logic                       filled_ff;
   logic [WORD_W-1:0]          rd_word_ff;
   logic                       rd_ok_ff;
   logic signed [SAMPLE_W-1:0] sum_ff;
   logic signed [SAMPLE_W-1:0] sum_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic [CFG_W-1:0]           mul_b;
   logic signed [PROD_W-1:0]   prod_in;
   logic [STORE_ADDR_BITS-1:0] rd_addr;
   logic signed [STORE_ADDR_BITS+1:0] diff;
   logic                       snap;
   logic signed [FB_W-1:0]     fb_full;

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_OFFSET: begin
            mul_a = $signed({{(MUL_A_W-STORE_ADDR_BITS){1'b0}}, offset_ff});
            mul_b = FP_ONE - cfg.smoothing;
         end
         MUL_TARGET: begin
            mul_a = $signed({{(MUL_A_W-STORE_ADDR_BITS){1'b0}}, cfg.delay_target});
            mul_b = cfg.smoothing;
         end
         MUL_FEEDBACK: begin
            mul_a = rd_ok_ff ? MUL_A_W'($signed(rd_word_ff)) : '0;
            mul_b = FP_ONE - cfg.decay;
         end
         MUL_GAIN: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = cfg.out_gain;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * $signed({1'b0, mul_b});

   // offset glide
   assign diff = $signed({2'b00, offset_ff}) - $signed({2'b00, cfg.delay_target});
   assign snap = (diff > -(STORE_ADDR_BITS+2)'(SNAP_DIST))
              && (diff < (STORE_ADDR_BITS+2)'(SNAP_DIST));
   assign offset_in = snap ? cfg.delay_target
                           : acc_ff + prod_ff[FRAC_BITS +: STORE_ADDR_BITS];

   assign rd_addr = wp_ff - offset_ff;

   // stored word widened to a sample before the feedback scale
   assign fb_full = $signed({prod_ff, {WORD_W{1'b0}}}) >>> FRAC_BITS;
   assign sum_in  = in_ff + fb_full[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_in) in_ff <= req_in_sample;
      if (cmd.mul_go) prod_ff <= prod_in;
      if (cmd.acc_load) acc_ff <= prod_ff[FRAC_BITS +: STORE_ADDR_BITS];
      if (cmd.mem_write) sum_ff <= sum_in;
      if (cmd.out_load) begin
         rsp_data_ff <= cfg.mute ? '0 : prod_ff[FRAC_BITS +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_word_ff <= echo_mem[rd_addr];
         rd_ok_ff   <= filled_ff || (rd_addr < wp_ff);
      end
      if (cmd.mem_write) echo_mem[wp_ff] <= sum_in[SAMPLE_W-1 -: WORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         wp_ff        <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.offs_load) offset_ff <= offset_in;
         if (cmd.mem_write) begin
            wp_ff <= wp_ff + 1'b1;
            if (wp_ff == STORE_MASK) filled_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_data_ff;

endmodule
